### rtl/mws_pkg.sv
// Shared types and constants of the minimum width search sequencer.
package mws_pkg;

    localparam int WIDTH_LIMIT = 305;

    localparam logic [2:0] ST_TRY      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_TOO_WIDE = 3'd2;
    localparam logic [2:0] ST_ODD      = 3'd3;
    localparam logic [2:0] ST_FLEX     = 3'd4;
    localparam logic [2:0] ST_FIXED    = 3'd5;

    localparam logic KIND_START = 1'b0;

    localparam logic [2:0] CFG_FIXED_EN  = 3'd0;
    localparam logic [2:0] CFG_FIXED_W   = 3'd1;
    localparam logic [2:0] CFG_UNIDIR    = 3'd2;
    localparam logic [2:0] CFG_FLEX      = 3'd3;
    localparam logic [2:0] CFG_PINS      = 3'd4;
    localparam logic [2:0] CFG_VERIFY_EN = 3'd5;

    typedef struct packed {
        logic       fixed_width_enable;
        logic [9:0] fixed_width;
        logic       unidirectional;
        logic [7:0] switch_flexibility;
        logic [9:0] max_block_pins;
        logic       verify_enable;
    } cfg_t;

    typedef struct packed {
        logic kind;
        logic route_ok;
        logic trial_clipped;
    } item_t;

endpackage

### rtl/mws_cfg.sv
// Configuration register file of the minimum width search sequencer.
module mws_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [9:0]    cfg_data,
    output mws_pkg::cfg_t cfg
);

    mws_pkg::cfg_t cfg_reg;
    mws_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mws_pkg::CFG_FIXED_EN:  cfg_next.fixed_width_enable = cfg_data[0];
                mws_pkg::CFG_FIXED_W:   cfg_next.fixed_width        = cfg_data;
                mws_pkg::CFG_UNIDIR:    cfg_next.unidirectional     = cfg_data[0];
                mws_pkg::CFG_FLEX:      cfg_next.switch_flexibility = cfg_data[7:0];
                mws_pkg::CFG_PINS:      cfg_next.max_block_pins     = cfg_data;
                mws_pkg::CFG_VERIFY_EN: cfg_next.verify_enable      = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fixed_width_enable <= 1'b0;
            cfg_reg.fixed_width        <= 10'd1;
            cfg_reg.unidirectional     <= 1'b0;
            cfg_reg.switch_flexibility <= 8'd3;
            cfg_reg.max_block_pins     <= 10'd0;
            cfg_reg.verify_enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mws_seq.sv
// Search state machine with bound registers and the result register.
module mws_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  mws_pkg::cfg_t      cfg,
    input  logic               item_valid,
    input  mws_pkg::item_t     item,
    input  logic               out_stall,
    output logic               take,
    output logic               out_valid,
    output logic [2:0]         status,
    output logic signed [13:0] width,
    output logic               verifying
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_VERIFY
    } phase_t;

    typedef logic signed [15:0] sw_t;

    localparam sw_t ONE       = 16'sd1;
    localparam sw_t TWO       = 16'sd2;
    localparam sw_t MINUS_ONE = -16'sd1;

    phase_t             phase_reg, phase_next;
    logic signed [13:0] trial_reg, low_reg, high_reg, best_reg;
    logic               pp_reg, pp_next, pp2_reg, pp2_next;
    logic               out_vld_reg, out_vld_next;
    logic [2:0]         status_reg, status_next;
    logic signed [13:0] width_reg, width_next;
    logic               ver_reg, ver_next;

    sw_t  t, lo, hi, best, m, fixed_s, lim, sum;
    logic emit, go_search, go_finish, go_verify, done;
    logic [15:0] flex_q;
    logic [7:0]  flex_r;

    function automatic sw_t ext14(input logic signed [13:0] x);
        ext14 = {{2{x[13]}}, x};
    endfunction

    function automatic sw_t half(input sw_t x);
        half = (x + sw_t'({15'd0, x[15]})) >>> 1;
    endfunction

    assign take = item_valid && (!out_vld_reg || !out_stall);

    // flexibility mod 3 via reciprocal multiply, exact for 8-bit values
    assign flex_q = ({8'd0, cfg.switch_flexibility} * 16'd171) >> 9;
    assign flex_r = cfg.switch_flexibility - 8'(flex_q * 16'd3);

    always_comb
    begin
        phase_next  = phase_reg;
        t           = ext14(trial_reg);
        lo          = ext14(low_reg);
        hi          = ext14(high_reg);
        best        = ext14(best_reg);
        pp_next     = pp_reg;
        pp2_next    = pp2_reg;
        emit        = 1'b0;
        status_next = mws_pkg::ST_TRY;
        width_next  = 14'sd0;
        ver_next    = 1'b0;
        go_search   = 1'b0;
        go_finish   = 1'b0;
        go_verify   = 1'b0;
        done        = 1'b0;
        sum         = '0;
        m           = cfg.unidirectional ? TWO : ONE;
        fixed_s     = {6'd0, cfg.fixed_width};
        lim         = cfg.fixed_width_enable ? {4'd0, cfg.fixed_width, 2'b00}
                                             : sw_t'(mws_pkg::WIDTH_LIMIT);

        if (item.kind == mws_pkg::KIND_START)
        begin
            if (cfg.fixed_width_enable)
            begin
                t  = fixed_s + (m <<< 2) + m;
                lo = fixed_s - m;
            end
            else
            begin
                t  = {6'd0, cfg.max_block_pins} + {15'd0, cfg.max_block_pins[0]};
                lo = MINUS_ONE;
            end
            hi       = MINUS_ONE;
            best     = MINUS_ONE;
            pp_next  = 1'b1;
            pp2_next = 1'b1;
            if (cfg.unidirectional)
            begin
                if (t[0])
                begin
                    emit        = 1'b1;
                    status_next = mws_pkg::ST_ODD;
                    width_next  = t[13:0];
                end
                else
                begin
                    go_search = 1'b1;
                end
            end
            else if (flex_r != 8'd0)
            begin
                emit        = 1'b1;
                status_next = mws_pkg::ST_FLEX;
                width_next  = t[13:0];
            end
            else
            begin
                go_search = 1'b1;
            end
        end
        else if (phase_reg == PH_SEARCH)
        begin
            if (item.route_ok && !item.trial_clipped)
            begin
                hi = t;
                if (hi - lo <= m)
                    done = 1'b1;
                sum = (lo != MINUS_ONE) ? hi + lo : hi;
                t   = half(sum);
            end
            else
            begin
                lo = t;
                if (hi != MINUS_ONE)
                begin
                    if (hi - lo <= m)
                        done = 1'b1;
                    sum = hi + lo;
                    t   = half(sum);
                end
                else if (cfg.fixed_width_enable)
                begin
                    if (lo < fixed_s + 16'sd30)
                    begin
                        t = lo + (m <<< 2) + m;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        status_next = mws_pkg::ST_FIXED;
                        width_next  = t[13:0];
                    end
                end
                else
                begin
                    t = lo <<< 1;
                end
            end
            // signed remainder by the unit added back
            if (cfg.unidirectional && t[0])
                t = t + (t[15] ? MINUS_ONE : ONE);
            if (!emit)
            begin
                if (done)
                begin
                    best      = hi;
                    go_finish = 1'b1;
                end
                else
                begin
                    go_search = 1'b1;
                end
            end
        end
        else if (phase_reg == PH_VERIFY)
        begin
            if (item.route_ok && !item.trial_clipped)
                best = t;
            pp2_next  = pp_reg;
            pp_next   = item.route_ok;
            t         = t - m;
            go_verify = 1'b1;
        end

        if (go_search)
        begin
            if (t > lim)
            begin
                emit        = 1'b1;
                status_next = mws_pkg::ST_TOO_WIDE;
                width_next  = t[13:0];
            end
            else if ((t <<< 1) + t < sw_t'({8'd0, cfg.switch_flexibility}))
            begin
                best      = hi;
                go_finish = 1'b1;
            end
            else
            begin
                phase_next  = PH_SEARCH;
                emit        = 1'b1;
                status_next = mws_pkg::ST_TRY;
                width_next  = t[13:0];
            end
        end

        if (go_finish)
        begin
            if (cfg.verify_enable)
            begin
                pp_next   = 1'b1;
                pp2_next  = 1'b1;
                t         = best - TWO;
                go_verify = 1'b1;
            end
            else
            begin
                emit        = 1'b1;
                status_next = mws_pkg::ST_DONE;
                width_next  = best[13:0];
            end
        end

        if (go_verify)
        begin
            if (!(pp_next || pp2_next) || (cfg.fixed_width_enable && t < fixed_s)
                || t < ONE)
            begin
                emit        = 1'b1;
                status_next = mws_pkg::ST_DONE;
                width_next  = best[13:0];
            end
            else
            begin
                phase_next  = PH_VERIFY;
                emit        = 1'b1;
                status_next = mws_pkg::ST_TRY;
                width_next  = t[13:0];
                ver_next    = 1'b1;
            end
        end

        if (emit && status_next != mws_pkg::ST_TRY)
            phase_next = PH_IDLE;

        out_vld_next = take ? emit : (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            trial_reg   <= 14'sd0;
            low_reg     <= -14'sd1;
            high_reg    <= -14'sd1;
            best_reg    <= -14'sd1;
            pp_reg      <= 1'b1;
            pp2_reg     <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (take)
            begin
                phase_reg <= phase_next;
                trial_reg <= t[13:0];
                low_reg   <= lo[13:0];
                high_reg  <= hi[13:0];
                best_reg  <= best[13:0];
                pp_reg    <= pp_next;
                pp2_reg   <= pp2_next;
                if (emit)
                begin
                    status_reg <= status_next;
                    width_reg  <= width_next;
                    ver_reg    <= ver_next;
                end
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign width     = width_reg;
    assign verifying = ver_reg;

endmodule

### rtl/min_width_search_controller.sv
// Top level of the minimum width search sequencer.
//
// Input channel (in_valid/in_stall) carries one beat per command: kind 0
// starts a new search, kind 1 reports the outcome of the last proposed trial
// (route_ok, trial_clipped). Output channel (out_valid/out_stall) carries one
// result beat per handled command: status, width and the verifying flag.
// An outcome beat that arrives while no search runs gives no result.
// A beat is registered at acceptance; its result is then registered in the
// output register, which drives out_valid. The step logic sits between the
// input and result registers; one beat per cycle is sustained while the
// receiver does not stall.
// When the receiver stalls, the result holds and the held input beat waits,
// so in_stall rises only while both registers are full.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait; the user
// must write it only while the block is idle, the block itself does not enforce this.
// Reset (rst_n, asynchronous, active low) empties both registers, loads the
// register defaults and returns the sequencer to idle.
module min_width_search_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic               route_ok,
    input  logic               trial_clipped,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [13:0] width,
    output logic               verifying
);

    mws_pkg::cfg_t  cfg;
    mws_pkg::item_t item_reg;
    logic           in_vld_reg, in_vld_next;
    logic           take;

    mws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_stall    = in_vld_reg && !take;
    assign in_vld_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (in_valid && !in_stall)
            begin
                item_reg.kind          <= kind;
                item_reg.route_ok      <= route_ok;
                item_reg.trial_clipped <= trial_clipped;
            end
        end
    end

    mws_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_vld_reg),
        .item       (item_reg),
        .out_stall  (out_stall),
        .take       (take),
        .out_valid  (out_valid),
        .status     (status),
        .width      (width),
        .verifying  (verifying)
    );

endmodule
